// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the interpolator.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lhpi_pkg.sv =====
// Shared types, codes and filter arithmetic of the luma half-pel interpolator.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package lhpi_pkg;

  // Item opcodes (carried in tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Sample positions
  localparam logic [1:0] POS_FULL = 2'd0;
  localparam logic [1:0] POS_HORZ = 2'd1;
  localparam logic [1:0] POS_VERT = 2'd2;
  localparam logic [1:0] POS_DIAG = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;
  localparam logic [7:0] FRAME_DIM_RESET = 8'd128;

  // Field widths
  localparam int unsigned COORD_W = 7;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned POS_W   = 2;
  localparam int unsigned TDATA_W = 24;

  // Six-tap filter: 1,-5,20,20,-5,1, round by 16, shift by 5, clip to 0..255
  localparam int unsigned TAP_IDX_W  = 3;
  localparam logic [TAP_IDX_W-1:0] TAP_FIRST  = 3'd0;
  localparam logic [TAP_IDX_W-1:0] TAP_CENTER = 3'd2;
  localparam logic [TAP_IDX_W-1:0] TAP_LAST   = 3'd5;
  localparam int unsigned COEF_W = 6;
  localparam int TAP_OUTER = 1;
  localparam int TAP_NEAR  = -5;
  localparam int TAP_INNER = 20;
  localparam int unsigned SUM_W = 16;
  localparam int TAP_ROUND = 16;
  localparam int TAP_SHIFT = 5;
  localparam int PIX_MAX   = 255;

  // One tap fetch issued by the controller
  typedef struct packed {
    logic                 valid;
    logic                 hfilt;
    logic                 vfilt;
    logic [TAP_IDX_W-1:0] row_idx;
    logic [TAP_IDX_W-1:0] col_idx;
    logic                 row_first;
    logic                 row_last;
    logic                 col_first;
    logic                 col_last;
  } tap_cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;
    logic     store;
    tap_cmd_t tap;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_done;
  } dp_status_t;

  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [TAP_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      3'd0, 3'd5: c = COEF_W'(TAP_OUTER);
      3'd1, 3'd4: c = COEF_W'(TAP_NEAR);
      3'd2, 3'd3: c = COEF_W'(TAP_INNER);
      default:    c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [SUM_W-1:0] tap_mul(input logic [TAP_IDX_W-1:0] idx,
                                                      input logic [PIX_W-1:0] pix);
    logic signed [SUM_W-1:0] p;
    p = SUM_W'($signed({1'b0, pix})) * SUM_W'(tap_coef(idx));
    return p;
  endfunction

  function automatic logic [PIX_W-1:0] round_clip(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] v;
    v = (SUM_W+1)'(s) + (SUM_W+1)'(TAP_ROUND);
    if (v < 0) begin
      return '0;
    end
    v = v >>> TAP_SHIFT;
    if (v > (SUM_W+1)'(PIX_MAX)) begin
      return PIX_W'(PIX_MAX);
    end
    return v[PIX_W-1:0];
  endfunction

endpackage

// ===== rtl/lhpi_ctrl.sv =====
// Controller of the interpolator: accepts items and walks the tap window.
// Depends on lhpi_pkg; drives the datapath by ctrl_cmd_t, listens to dp_status_t.
`timescale 1ns / 1ps

module lhpi_ctrl
  import lhpi_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             opcode_i,
  input  logic [POS_W-1:0] position_i,
  input  dp_status_t       status_i,
  output ctrl_cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  state_e               state_q;
  logic [TAP_IDX_W-1:0] ri_q;
  logic [TAP_IDX_W-1:0] ci_q;
  logic                 hf_q;
  logic                 vf_q;

  logic                 accept;
  logic                 in_hf;
  logic                 in_vf;
  logic [TAP_IDX_W-1:0] rstart, rend, cstart, cend;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_hf      = (position_i == POS_HORZ) || (position_i == POS_DIAG);
  assign in_vf      = (position_i == POS_VERT) || (position_i == POS_DIAG);

  // Window bounds: six taps along a filtered axis, the center tap otherwise
  assign rstart = vf_q ? TAP_FIRST : TAP_CENTER;
  assign rend   = vf_q ? TAP_LAST  : TAP_CENTER;
  assign cstart = hf_q ? TAP_FIRST : TAP_CENTER;
  assign cend   = hf_q ? TAP_LAST  : TAP_CENTER;

  // Commands to the datapath
  always_comb begin
    cmd_o               = '0;
    cmd_o.load          = accept;
    cmd_o.store         = accept && (opcode_i == OP_WRITE);
    cmd_o.tap.valid     = (state_q == ST_ISSUE);
    cmd_o.tap.hfilt     = hf_q;
    cmd_o.tap.vfilt     = vf_q;
    cmd_o.tap.row_idx   = ri_q;
    cmd_o.tap.col_idx   = ci_q;
    cmd_o.tap.row_first = (ri_q == rstart);
    cmd_o.tap.row_last  = (ri_q == rend);
    cmd_o.tap.col_first = (ci_q == cstart);
    cmd_o.tap.col_last  = (ci_q == cend);
  end

  // Sequence one read item: column taps inside row taps, then wait for the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ri_q    <= TAP_CENTER;
      ci_q    <= TAP_CENTER;
      hf_q    <= 1'b0;
      vf_q    <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (opcode_i == OP_READ)) begin
            hf_q    <= in_hf;
            vf_q    <= in_vf;
            ri_q    <= in_vf ? TAP_FIRST : TAP_CENTER;
            ci_q    <= in_hf ? TAP_FIRST : TAP_CENTER;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          if (ci_q == cend) begin
            ci_q <= cstart;
            if (ri_q == rend) begin
              state_q <= ST_WAIT;
            end else begin
              ri_q <= ri_q + 1'b1;
            end
          end else begin
            ci_q <= ci_q + 1'b1;
          end
        end
        ST_WAIT: begin
          if (status_i.item_done) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lhpi_datapath.sv =====
// Datapath of the interpolator: frame size registers, pixel memory, the two
// filter stages and the output register. Depends on lhpi_pkg.
`timescale 1ns / 1ps

module lhpi_datapath
  import lhpi_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [7:0]           cfg_data_i,
  input  logic [COORD_W-1:0]   row_i,
  input  logic [COORD_W-1:0]   col_i,
  input  logic [PIX_W-1:0]     pixel_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [PIX_W-1:0]     sample_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CIW   = $clog2(MAX_WIDTH);
  localparam int RIW   = $clog2(MAX_HEIGHT);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int MW    = (XW > YW) ? XW : YW;
  localparam int KW    = ((MW > 9) ? MW : 9) + 1;
  localparam logic signed [KW-1:0] MAXW_K = KW'(MAX_WIDTH);
  localparam logic signed [KW-1:0] MAXH_K = KW'(MAX_HEIGHT);
  localparam logic signed [KW-1:0] ONE_K  = KW'(1);
  localparam logic signed [KW-1:0] CTR_K  = KW'(TAP_CENTER);
  localparam logic [AW-1:0]        STRIDE = AW'(MAX_WIDTH);

  function automatic logic signed [KW-1:0] clamp_k(input logic signed [KW-1:0] v,
                                                   input logic signed [KW-1:0] lim);
    if (v < 0) begin
      return '0;
    end
    if (v >= lim) begin
      return lim - ONE_K;
    end
    return v;
  endfunction

  logic [7:0]               fw_q, fh_q;
  logic [COORD_W-1:0]       r_q, c_q;
  logic signed [KW-1:0]     ew, eh, fw_k, fh_k;
  logic signed [KW-1:0]     base_r, base_c, tap_r, tap_c;
  logic [AW-1:0]            waddr, raddr;

  logic [PIX_W-1:0]         mem [DEPTH];
  logic [PIX_W-1:0]         rdata_q;
  tap_cmd_t                 cmd_q;

  logic signed [SUM_W-1:0]  hacc_q, hsum;
  logic [PIX_W-1:0]         hval_q;
  logic                     hv_valid_q;
  tap_cmd_t                 hcmd_q;
  logic signed [SUM_W-1:0]  vacc_q, vsum;
  logic [PIX_W-1:0]         res_q;
  logic                     res_valid_q;
  logic                     out_valid_q;
  logic [PIX_W-1:0]         out_q;
  logic                     move;

  // Frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_DIM_RESET;
      fh_q <= FRAME_DIM_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_addr_i == CFG_FRAME_WIDTH) begin
        fw_q <= cfg_data_i;
      end else if (cfg_addr_i == CFG_FRAME_HEIGHT) begin
        fh_q <= cfg_data_i;
      end
    end
  end

  // Effective frame size: zero acts as one, cap at the memory size
  assign fw_k = $signed({{(KW-8){1'b0}}, fw_q});
  assign fh_k = $signed({{(KW-8){1'b0}}, fh_q});
  assign ew   = (fw_q == 8'd0) ? ONE_K : ((fw_k > MAXW_K) ? MAXW_K : fw_k);
  assign eh   = (fh_q == 8'd0) ? ONE_K : ((fh_k > MAXH_K) ? MAXH_K : fh_k);

  // Clamp the item coordinates into the frame
  assign base_r = clamp_k($signed({{(KW-COORD_W){1'b0}}, row_i}), eh);
  assign base_c = clamp_k($signed({{(KW-COORD_W){1'b0}}, col_i}), ew);
  assign waddr  = AW'(AW'(base_r[RIW-1:0]) * STRIDE) + AW'(base_c[CIW-1:0]);

  // Hold the clamped coordinates of the item in work
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= base_r[COORD_W-1:0];
      c_q <= base_c[COORD_W-1:0];
    end
  end

  // Tap address: offset from the center, replicated at the frame edges
  assign tap_r = clamp_k($signed({{(KW-COORD_W){1'b0}}, r_q})
                         + $signed({{(KW-TAP_IDX_W){1'b0}}, cmd_i.tap.row_idx}) - CTR_K, eh);
  assign tap_c = clamp_k($signed({{(KW-COORD_W){1'b0}}, c_q})
                         + $signed({{(KW-TAP_IDX_W){1'b0}}, cmd_i.tap.col_idx}) - CTR_K, ew);
  assign raddr = AW'(AW'(tap_r[RIW-1:0]) * STRIDE) + AW'(tap_c[CIW-1:0]);

  // Pixel memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[waddr] <= pixel_i;
    end
    if (cmd_i.tap.valid) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i.tap;
    end
  end

  // Horizontal stage: accumulate one row of taps, round and clip at its end if hfilt is set, else pass the tap
  assign hsum = (cmd_q.col_first ? '0 : hacc_q) + tap_mul(cmd_q.col_idx, rdata_q);

  always_ff @(posedge clk_i) begin
    if (cmd_q.valid) begin
      hacc_q <= hsum;
      if (cmd_q.col_last) begin
        hval_q <= cmd_q.hfilt ? round_clip(hsum) : rdata_q;
        hcmd_q <= cmd_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_valid_q <= 1'b0;
    end else begin
      hv_valid_q <= cmd_q.valid && cmd_q.col_last;
    end
  end

  // Vertical stage: accumulate the row results, round and clip at the last row if vfilt is set, else pass the row
  assign vsum = (hcmd_q.row_first ? '0 : vacc_q) + tap_mul(hcmd_q.row_idx, hval_q);

  always_ff @(posedge clk_i) begin
    if (hv_valid_q) begin
      vacc_q <= vsum;
      if (hcmd_q.row_last) begin
        res_q <= hcmd_q.vfilt ? round_clip(vsum) : hval_q;
      end
    end
    if (move) begin
      out_q <= res_q;
    end
  end

  // Result handoff into the output register when it is free or being drained
  assign move = res_valid_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (hv_valid_q && hcmd_q.row_last) begin
        res_valid_q <= 1'b1;
      end else if (move) begin
        res_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.item_done = move;
  assign out_valid_o        = out_valid_q;
  assign sample_o           = out_q;

endmodule

// ===== rtl/luma_half_pel_interpolator.sv =====
// Luma half-pel interpolator: stores an 8-bit luma frame and answers reads
// with full, horizontal, vertical or diagonal half-pel samples.
// Depends on lhpi_pkg, lhpi_ctrl and lhpi_datapath.
//
// Channels: the slave stream carries items; tuser holds the opcode (write or
// read), tdata the row, column, pixel and position. A write stores the pixel
// at the clamped coordinate and gives no result. A read gives one sample on
// the master stream. The configuration channel writes frame_width (index 0)
// and frame_height (index 1); it is always ready and must be used only while
// idle, which the block does not enforce. Timing: a write leaves the block
// ready for the next item. A read fetches one tap per cycle through the single
// read port of the pixel memory, then passes two filter stages; a full pel
// fetches one tap, a horizontal or vertical half pel 6, a diagonal half pel 36.
// The next item is accepted only once a read's result enters the output register.
// Reset clears the control state and sets the frame size to 128 x 128; pixel
// contents are undefined until written. A result waits in the output register
// while the receiver stalls, and the next item is still accepted; its own
// result then waits in the datapath until the output register drains.
`timescale 1ns / 1ps

module luma_half_pel_interpolator
  import lhpi_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [7:0]           cfg_data_i,
  // Item input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,  // row[6:0], col[13:7], pixel_in[21:14], position[23:22]
  input  logic [0:0]           s_axis_tuser,  // opcode[0]
  // Result output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PIX_W-1:0]     m_axis_tdata   // sample[7:0]
);

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [COORD_W-1:0] in_row, in_col;
  logic [PIX_W-1:0]   in_pixel;
  logic [POS_W-1:0]   in_position;

  // Unpack the item fields
  assign in_row      = s_axis_tdata[6:0];
  assign in_col      = s_axis_tdata[13:7];
  assign in_pixel    = s_axis_tdata[21:14];
  assign in_position = s_axis_tdata[23:22];
  assign cfg_ready_o = 1'b1;

  lhpi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser[0]),
    .position_i (in_position),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lhpi_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (in_row),
    .col_i       (in_col),
    .pixel_i     (in_pixel),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sample_o    (m_axis_tdata)
  );

endmodule

// ===== rtl/lhpi_checker.sv =====
// Port-level checker of the interpolator, bound to the top level.
// Depends on lhpi_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lhpi_checker
  import lhpi_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [0:0]       s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [PIX_W-1:0] m_axis_tdata
);

  logic in_take;
  logic in_read;
  logic out_stall;

  // Handshake terms seen on the ports
  assign in_take   = s_axis_tvalid && s_axis_tready;
  assign in_read   = in_take && (s_axis_tuser[0] == OP_READ);
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid, "result dropped while stalled")
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(m_axis_tdata), "stalled result changed")

  // A read item keeps the block busy for its tap fetches
  `ASSERT_NEXT(a_read_busy, clk_i, rst_ni, in_read, !s_axis_tready, "item accepted during tap fetch")

  // No result appears right after an item is accepted
  `ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_take, !$rose(m_axis_tvalid), "result too early")

  // A stalled result is only left behind when the receiver takes it
  `ASSERT_IMPLIES(a_fall_on_ready, clk_i, rst_ni, $fell(m_axis_tvalid), $past(m_axis_tready), "result withdrawn")

endmodule

bind luma_half_pel_interpolator lhpi_checker u_lhpi_checker (.*);

// ===== sim/tb_luma_half_pel_interpolator.sv =====
// Self-checking testbench for luma_half_pel_interpolator: loads pixels, reads
// full and half-pel samples and compares each against a built-in predictor.
// Depends on lhpi_pkg and the RTL of the interpolator only.
`timescale 1ns / 1ps

module tb_luma_half_pel_interpolator;
  import lhpi_pkg::*;

  localparam int MAX_COLS     = 128;
  localparam int MAX_ROWS     = 128;
  localparam int DRAIN_CYCLES = 48;
  localparam int LONG_HOLD    = 300;
  localparam int PHASE_ITEMS  = 140;
  localparam int NUM_PHASES   = 10;
  localparam int MAX_REPORTS  = 10;

  // Predicts samples from a private copy of the frame and the frame size
  class luma_sample_scoreboard;
    bit [7:0]    luma [MAX_ROWS*MAX_COLS];
    bit          filled [MAX_ROWS*MAX_COLS];
    bit [7:0]    width_reg;
    bit [7:0]    height_reg;
    bit [7:0]    pending [$];
    int unsigned n_writes;
    int unsigned n_reads;
    int unsigned n_checked;
    int unsigned n_bad;
    int unsigned pos_count [4];

    function new();
      width_reg  = 8'd128;
      height_reg = 8'd128;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [7:0] val);
      if (idx == CFG_FRAME_WIDTH) begin
        width_reg = val;
      end else if (idx == CFG_FRAME_HEIGHT) begin
        height_reg = val;
      end
    endfunction

    function int eff_w();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_COLS) return MAX_COLS;
      return width_reg;
    endfunction

    function int eff_h();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_ROWS) return MAX_ROWS;
      return height_reg;
    endfunction

    function int clampi(int v, int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
    endfunction

    function int pel(int r, int c);
      return luma[clampi(r, eff_h())*MAX_COLS + clampi(c, eff_w())];
    endfunction

    // 1,-5,20,20,-5,1 with rounding and clipping
    function int filter6(int a, int b, int c, int d, int e, int f);
      int v;
      v = a - 5*b + 20*c + 20*d - 5*e + f + 16;
      if (v < 0) return 0;
      v = v >>> 5;
      if (v > 255) return 255;
      return v;
    endfunction

    function int horz_half(int r, int c);
      return filter6(pel(r, c-2), pel(r, c-1), pel(r, c), pel(r, c+1), pel(r, c+2),
                     pel(r, c+3));
    endfunction

    function int vert_half(int r, int c);
      return filter6(pel(r-2, c), pel(r-1, c), pel(r, c), pel(r+1, c), pel(r+2, c),
                     pel(r+3, c));
    endfunction

    // Vertical filter over already clipped horizontal half pels
    function int diag_half(int r, int c);
      return filter6(horz_half(r-2, c), horz_half(r-1, c), horz_half(r, c),
                     horz_half(r+1, c), horz_half(r+2, c), horz_half(r+3, c));
    endfunction

    function void note_item(bit op, bit [6:0] row, bit [6:0] col, bit [7:0] pix,
                            bit [1:0] pos);
      int r;
      int c;
      int s;
      r = clampi(row, eff_h());
      c = clampi(col, eff_w());
      if (op == OP_WRITE) begin
        luma[r*MAX_COLS + c]   = pix;
        filled[r*MAX_COLS + c] = 1'b1;
        n_writes++;
        return;
      end
      case (pos)
        POS_FULL: s = pel(r, c);
        POS_HORZ: s = horz_half(r, c);
        POS_VERT: s = vert_half(r, c);
        default:  s = diag_half(r, c);
      endcase
      pending.push_back(8'(s));
      n_reads++;
      pos_count[pos]++;
    endfunction

    function void check_sample(bit [7:0] got);
      bit [7:0] want;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS) $display("ERROR: sample %0d arrived with none expected", got);
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got !== want) begin
        n_bad++;
        if (n_bad <= MAX_REPORTS) begin
          $display("ERROR: sample %0d: expected %0d, got %0d", n_checked, want, got);
        end
      end
    endfunction

    // True when every tap a read at (row, col) can touch holds a written pixel
    function bit box_written(int row, int col);
      int r;
      int c;
      int dr;
      int dc;
      r = clampi(row, eff_h());
      c = clampi(col, eff_w());
      for (dr = -2; dr <= 3; dr++) begin
        for (dc = -2; dc <= 3; dc++) begin
          if (!filled[clampi(r+dr, eff_h())*MAX_COLS + clampi(c+dc, eff_w())]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // First unwritten tap position of a read at (row, col)
    function void find_gap(int row, int col, output int gr, output int gc);
      int r;
      int c;
      int dr;
      int dc;
      r  = clampi(row, eff_h());
      c  = clampi(col, eff_w());
      gr = r;
      gc = c;
      for (dr = -2; dr <= 3; dr++) begin
        for (dc = -2; dc <= 3; dc++) begin
          if (!filled[clampi(r+dr, eff_h())*MAX_COLS + clampi(c+dc, eff_w())]) begin
            gr = clampi(r+dr, eff_h());
            gc = clampi(c+dc, eff_w());
            return;
          end
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_addr_i;
  logic [7:0]           cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata;  // row[6:0], col[13:7], pixel_in[21:14], position[23:22]
  logic [0:0]           s_axis_tuser;  // opcode[0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [PIX_W-1:0]     m_axis_tdata;  // sample[7:0]

  luma_sample_scoreboard sb;
  bit                    calm;
  bit                    hold_off_req;
  int unsigned           n_phases;

  luma_half_pel_interpolator #(
    .MAX_WIDTH (MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // Hold the run to a fixed budget
  initial begin : watchdog
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Check results and stall the result stream in bursts and one long hold
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_sample(m_axis_tdata);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one item and wait for it to be taken
  task automatic send_item(input logic op, input int row, input int col,
                           input logic [7:0] pix, input logic [1:0] pos);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pos, pix, col[6:0], row[6:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(op, row[6:0], col[6:0], pix, pos);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Stop offering items until every expected sample is back and the block settles
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic int pick_origin(int dim, int size);
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return dim - size;
      default: return $urandom_range(0, dim - size);
    endcase
  endfunction

  // Coordinate inside the window, sometimes past the far frame edge
  function automatic int pick_coord(int origin, int size, int dim);
    if (origin + size >= dim && $urandom_range(0, 2) == 0) return $urandom_range(dim - 1, 127);
    return origin + $urandom_range(0, size - 1);
  endfunction

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int phase_w [NUM_PHASES];
    int phase_h [NUM_PHASES];
    int p;
    int n;
    int i;
    int j;
    int ew;
    int eh;
    int win_r;
    int win_c;
    int win_h;
    int win_w;
    int r;
    int c;
    int gr;
    int gc;

    sb           = new();
    calm         = 1'b0;
    hold_off_req = 1'b0;
    n_phases     = 3;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_WRITE;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: corner patch at the reset frame size, bright row and column two
    for (i = 0; i < 4; i++) begin
      for (j = 0; j < 4; j++) begin
        send_item(OP_WRITE, i, j, (i == 2 || j == 2) ? 8'd255 : 8'(16*i + 3*j), POS_FULL);
      end
    end
    send_item(OP_READ, 0, 0, 8'd0, POS_FULL);
    send_item(OP_READ, 0, 0, 8'd0, POS_HORZ);
    send_item(OP_READ, 0, 0, 8'd0, POS_VERT);
    send_item(OP_READ, 0, 0, 8'd0, POS_DIAG);

    // Directed: 4x4 frame, coordinates beyond the frame clamp to the edge
    drain_results();
    write_cfg(CFG_FRAME_WIDTH, 8'd4);
    write_cfg(CFG_FRAME_HEIGHT, 8'd4);
    send_item(OP_READ, 127, 127, 8'hFF, POS_DIAG);
    send_item(OP_READ, 127, 127, 8'hFF, POS_HORZ);
    send_item(OP_READ, 1, 1, 8'd0, POS_VERT);

    // Directed: zero size acts as one pixel, every tap replicates it
    drain_results();
    write_cfg(CFG_FRAME_WIDTH, 8'd0);
    write_cfg(CFG_FRAME_HEIGHT, 8'd0);
    send_item(OP_WRITE, 127, 127, 8'd255, POS_DIAG);
    send_item(OP_READ, 90, 5, 8'd0, POS_DIAG);

    phase_w = '{8, 128, 255, 1, 128, 16, $urandom_range(1, 128), $urandom_range(1, 128), 2, 128};
    phase_h = '{8, 128, 200, 128, 1, 5, $urandom_range(1, 128), $urandom_range(1, 128), 3, 128};

    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_cfg(CFG_FRAME_WIDTH, 8'(phase_w[p]));
      write_cfg(CFG_FRAME_HEIGHT, 8'(phase_h[p]));
      // Writes to an index past the register list must change nothing
      if (p == 0 || p == 6) write_cfg(CFG_IDX_W'($urandom_range(CFG_FRAME_HEIGHT + 1, 255)),
                                       8'($urandom_range(0, 255)));
      n_phases++;
      calm = (p == NUM_PHASES - 1) || ($urandom_range(0, 4) == 0);
      if (p == 1) hold_off_req = 1'b1;
      ew = sb.eff_w();
      eh = sb.eff_h();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Move the read window; large frames keep one window per phase
        if (n == 0 || (ew * eh <= 256 && n % 35 == 0)) begin
          win_h = (eh < 4) ? $urandom_range(1, eh) : $urandom_range(1, 4);
          win_w = (ew < 4) ? $urandom_range(1, ew) : $urandom_range(1, 4);
          win_r = pick_origin(eh, win_h);
          win_c = pick_origin(ew, win_w);
        end
        if (p == 3 && n == 70) drain_results();
        if ($urandom_range(0, 9) == 0) begin
          send_item(OP_WRITE, $urandom_range(0, 127), $urandom_range(0, 127), pick_pixel(),
                    2'($urandom_range(0, 3)));
        end else begin
          r = pick_coord(win_r, win_h, eh);
          c = pick_coord(win_c, win_w, ew);
          if (sb.box_written(r, c)) begin
            send_item(OP_READ, r, c, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
          end else begin
            sb.find_gap(r, c, gr, gc);
            send_item(OP_WRITE, gr, gc, pick_pixel(), 2'($urandom_range(0, 3)));
          end
        end
      end
    end

    drain_results();
    $display("Covered %0d pixel writes and %0d reads over %0d frame sizes; %0d samples checked",
             sb.n_writes, sb.n_reads, n_phases, sb.n_checked);
    $display("Reads by position: full %0d, right %0d, lower %0d, diagonal %0d",
             sb.pos_count[POS_FULL], sb.pos_count[POS_HORZ], sb.pos_count[POS_VERT],
             sb.pos_count[POS_DIAG]);
    if (sb.n_bad == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
